### hdl/wg3_pkg.sv
// ----------------------------------------------------------------------------
// wg3_pkg
// Shared types, constants and helpers for the weighted 3x3 Gaussian filter.
// ----------------------------------------------------------------------------
package wg3_pkg;

  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned MAX_COLS = 4096;
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned RCFG_W   = ROW_W + 1;
  localparam int unsigned CCFG_W   = COL_W + 1;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned BETA_W   = 16;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned NTAPS    = 9;
  localparam int unsigned W_W      = ALPHA_W + BETA_W;
  localparam int unsigned P_W      = W_W + 1 + PIX_W;
  localparam int unsigned NUM_W    = P_W + 4;
  localparam int unsigned DEN_W    = W_W + 4;
  localparam int unsigned PADDR_W  = ROW_W + 2;
  localparam int unsigned WADDR_W  = ROW_W + 1;
  localparam int unsigned PDEPTH   = 1 << PADDR_W;
  localparam int unsigned WDEPTH   = 1 << WADDR_W;
  localparam int unsigned WROW_W   = NTAPS * BETA_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << 16);
  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_EDGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CORNER = 3'd3;

  typedef struct packed {
    logic signed [PIX_W-1:0] intensity;
    logic [BETA_W-1:0] beta_0;
    logic [BETA_W-1:0] beta_1;
    logic [BETA_W-1:0] beta_2;
    logic [BETA_W-1:0] beta_3;
    logic [BETA_W-1:0] beta_4;
    logic [BETA_W-1:0] beta_5;
    logic [BETA_W-1:0] beta_6;
    logic [BETA_W-1:0] beta_7;
    logic [BETA_W-1:0] beta_8;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] filtered;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic zero_weight;
    logic last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
  } tap_pos_t;

  // Window position of tap k: row and column offset plus one.
  function automatic tap_pos_t tap_pos(input logic [3:0] k);
    tap_pos_t t;
    case (k)
      4'd0: t = '{dr: 2'd0, dc: 2'd0};
      4'd1: t = '{dr: 2'd0, dc: 2'd1};
      4'd2: t = '{dr: 2'd0, dc: 2'd2};
      4'd3: t = '{dr: 2'd1, dc: 2'd0};
      4'd4: t = '{dr: 2'd1, dc: 2'd1};
      4'd5: t = '{dr: 2'd1, dc: 2'd2};
      4'd6: t = '{dr: 2'd2, dc: 2'd0};
      4'd7: t = '{dr: 2'd2, dc: 2'd1};
      default: t = '{dr: 2'd2, dc: 2'd2};
    endcase
    return t;
  endfunction

  function automatic logic [1:0] ring_inc(input logic [1:0] r);
    return (r == 2'd2) ? 2'd0 : r + 2'd1;
  endfunction

  function automatic logic [1:0] ring_dec(input logic [1:0] r);
    return (r == 2'd0) ? 2'd2 : r - 2'd1;
  endfunction

endpackage

### hdl/wg3_ram.sv
// ----------------------------------------------------------------------------
// wg3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wg3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/wg3_lane.sv
// ----------------------------------------------------------------------------
// wg3_lane
// One tap lane: weight w = alpha * beta, then product w * pixel.
// ----------------------------------------------------------------------------
module wg3_lane
  import wg3_pkg::*;
(
  input  logic                    clk_i,
  input  logic [ALPHA_W-1:0]      alpha_i,
  input  logic [BETA_W-1:0]       beta_i,
  input  logic signed [PIX_W-1:0] pix_i,
  input  logic signed [PIX_W-1:0] centre_i,
  output logic [W_W-1:0]          w_o,
  output logic signed [P_W-1:0]   p_o
);

  logic [W_W-1:0]          w_q, w2_q;
  logic signed [PIX_W-1:0] v_q;
  logic signed [P_W-1:0]   p_q;

  always_ff @(posedge clk_i) begin
    w_q  <= alpha_i * beta_i;
    // missing neighbor takes the center value
    v_q  <= pix_i[PIX_W-1] ? centre_i : pix_i;
    w2_q <= w_q;
    p_q  <= $signed({1'b0, w_q}) * v_q;
  end

  assign w_o = w2_q;
  assign p_o = p_q;

endmodule

### hdl/wg3_merge.sv
// ----------------------------------------------------------------------------
// wg3_merge
// Two-stage registered adder tree over the nine lanes.
// ----------------------------------------------------------------------------
module wg3_merge
  import wg3_pkg::*;
(
  input  logic                    clk_i,
  input  logic [W_W-1:0]          w_i [NTAPS],
  input  logic signed [P_W-1:0]   p_i [NTAPS],
  output logic [DEN_W-1:0]        den_o,
  output logic signed [NUM_W-1:0] num_o
);

  logic [DEN_W-1:0]        dpart_q [3];
  logic signed [NUM_W-1:0] npart_q [3];
  logic [DEN_W-1:0]        den_q;
  logic signed [NUM_W-1:0] num_q;

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < 3; g++) begin
      dpart_q[g] <= DEN_W'(w_i[3*g]) + DEN_W'(w_i[3*g+1]) + DEN_W'(w_i[3*g+2]);
      npart_q[g] <= NUM_W'(p_i[3*g]) + NUM_W'(p_i[3*g+1]) + NUM_W'(p_i[3*g+2]);
    end
    den_q <= dpart_q[0] + dpart_q[1] + dpart_q[2];
    num_q <= npart_q[0] + npart_q[1] + npart_q[2];
  end

  assign den_o = den_q;
  assign num_o = num_q;

endmodule

### hdl/wg3_div.sv
// ----------------------------------------------------------------------------
// wg3_div
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero and saturating to the pixel range; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module wg3_div
  import wg3_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [PIX_W-1:0] quo_o,
  output logic                    zero_o
);

  logic                    busy_q, done_q, neg_q, zero_q;
  logic [4:0]              cnt_q;
  logic [DEN_W-1:0]        rem_q, den_q;
  logic [PIX_W-1:0]        quo_q;
  logic signed [PIX_W-1:0] res_q;

  logic [NUM_W-1:0] mag;
  logic             neg;
  logic [DEN_W+1:0] trial;
  logic             fits;
  logic [PIX_W-1:0] quo_next;

  assign neg      = num_i[NUM_W-1];
  assign mag      = neg ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign trial    = {1'b0, rem_q, quo_q[PIX_W-1]} - {2'b00, den_q};
  assign fits     = ~trial[DEN_W+1];
  assign quo_next = {quo_q[PIX_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0 || mag >= {den_i, {PIX_W{1'b0}}}) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'(PIX_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= neg;
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      rem_q  <= mag[NUM_W-2:PIX_W];
      quo_q  <= mag[PIX_W-1:0];
      if (den_i == '0) begin
        res_q <= '0;
      end else begin
        res_q <= neg ? PIX_MIN : PIX_MAX;
      end
    end else if (busy_q) begin
      rem_q <= fits ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[PIX_W-1]};
      quo_q <= quo_next;
      if (cnt_q == 5'd1) begin
        if (neg_q) begin
          res_q <= (quo_next > PIX_W'(1 << (PIX_W-1))) ? PIX_MIN : $signed(-quo_next);
        end else begin
          res_q <= quo_next[PIX_W-1] ? PIX_MAX : $signed(quo_next);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;
  assign zero_o = zero_q;

endmodule

### hdl/weighted_gaussian_3x3_filter_core.sv
// ----------------------------------------------------------------------------
// weighted_gaussian_3x3_filter_core
// Column-major pixel stream in, normalized weighted 3x3 Gaussian out.
// ----------------------------------------------------------------------------
// An input transfer writes the stores and causes 0 to 4 results.
// Each result goes through setup, nine serial tap reads from the
// single-read pixel RAM, the lanes and adder tree, the bit-serial
// divider (which skips its iterations for a zero weight sum or a
// quotient far out of range) and output; the next input waits for all of them.
// Reset clears control state and positions and sets rows=cols=1, alphas=1.0;
// the pixel and weight RAMs are not cleared.
module weighted_gaussian_3x3_filter_core
  import wg3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [RCFG_W-1:0]  rows_q;
  logic [CCFG_W-1:0]  cols_q;
  logic [ALPHA_W-1:0] alpha_edge_q, alpha_corner_q;

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [1:0]       ring_q;

  // job captured at input transfer
  logic [ROW_W-1:0] job_row_q;
  logic [COL_W-1:0] job_col_q;
  logic [1:0]       job_ring_q;
  logic             job_cm1_q, job_rm1_q;
  logic [1:0]       ncols_q, nrows_q;
  logic             ca_q, cb_q;

  // current result
  logic [ROW_W-1:0] ri_q, rowm_q, rowp_q;
  logic [COL_W-1:0] rj_q;
  logic [1:0]       ringm_q, ringc_q, ringp_q;
  logic             last_q;
  logic [3:0]       cnt_q;

  logic signed [PIX_W-1:0] tap_q [NTAPS];
  out_item_t               out_q;
  logic                    out_valid_q;

  logic in_xfer, cfg_xfer, last_res;
  logic has_cm1, has_cc, has_rm1, has_rr;
  logic [ROW_W-1:0] s_i, s_rowm, s_rowp;
  logic [COL_W-1:0] s_j;
  logic [1:0]       s_ringc, s_ringm, s_ringp;
  tap_pos_t         tp;
  logic [ROW_W-1:0] p_row;
  logic [1:0]       p_ring;
  logic             prd_en, wrd_en;
  logic [PIX_W-1:0]  prd_data;
  logic [WROW_W-1:0] wrd_data;
  logic [W_W-1:0]          lane_w [NTAPS];
  logic signed [P_W-1:0]   lane_p [NTAPS];
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] num;
  logic                    div_start, div_done, div_zero;
  logic signed [PIX_W-1:0] div_quo;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  // hold register writes while a pixel is offered
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;

  assign has_cm1 = (col_q != '0);
  assign has_cc  = ({1'b0, col_q} == cols_q - CCFG_W'(1));
  assign has_rm1 = (row_q != '0);
  assign has_rr  = ({1'b0, row_q} == rows_q - RCFG_W'(1));

  // result coordinates for the current candidate
  always_comb begin
    s_j     = (!ca_q && job_cm1_q) ? job_col_q - COL_W'(1) : job_col_q;
    s_ringc = (!ca_q && job_cm1_q) ? ring_dec(job_ring_q) : job_ring_q;
    s_i     = (!cb_q && job_rm1_q) ? job_row_q - ROW_W'(1) : job_row_q;
    s_rowm  = (s_i == '0) ? s_i : s_i - ROW_W'(1);
    s_rowp  = ({1'b0, s_i} + RCFG_W'(1) >= rows_q) ? s_i : s_i + ROW_W'(1);
    s_ringm = (s_j == '0) ? s_ringc : ring_dec(s_ringc);
    s_ringp = ({1'b0, s_j} + CCFG_W'(1) >= cols_q) ? s_ringc : ring_inc(s_ringc);
  end

  assign last_res = (ca_q == (ncols_q == 2'd2)) && (cb_q == (nrows_q == 2'd2));

  // tap read address
  always_comb begin
    tp = tap_pos(cnt_q);
    case (tp.dr)
      2'd0:    p_row = rowm_q;
      2'd1:    p_row = ri_q;
      default: p_row = rowp_q;
    endcase
    case (tp.dc)
      2'd0:    p_ring = ringm_q;
      2'd1:    p_ring = ringc_q;
      default: p_ring = ringp_q;
    endcase
  end

  assign prd_en    = (state_q == S_FETCH) && (cnt_q < 4'(NTAPS));
  assign wrd_en    = (state_q == S_SETUP);
  assign div_start = (state_q == S_CALC) && (cnt_q == 4'd4);

  wg3_ram #(.WIDTH(PIX_W), .DEPTH(PDEPTH)) u_pix_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer),
    .wr_addr_i ({ring_q, row_q}),
    .wr_data_i (in_data_i.intensity),
    .rd_en_i   (prd_en),
    .rd_addr_i ({p_ring, p_row}),
    .rd_data_o (prd_data)
  );

  wg3_ram #(.WIDTH(WROW_W), .DEPTH(WDEPTH)) u_wgt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer),
    .wr_addr_i ({col_q[0], row_q}),
    .wr_data_i ({in_data_i.beta_8, in_data_i.beta_7, in_data_i.beta_6,
                 in_data_i.beta_5, in_data_i.beta_4, in_data_i.beta_3,
                 in_data_i.beta_2, in_data_i.beta_1, in_data_i.beta_0}),
    .rd_en_i   (wrd_en),
    .rd_addr_i ({s_j[0], s_i}),
    .rd_data_o (wrd_data)
  );

  for (genvar k = 0; k < NTAPS; k++) begin : g_lane
    localparam bit IsCentre = (k == 4);
    localparam bit IsCorner = (k == 0) || (k == 2) || (k == 6) || (k == 8);
    logic [ALPHA_W-1:0] alpha;
    assign alpha = IsCentre ? ALPHA_ONE : (IsCorner ? alpha_corner_q : alpha_edge_q);
    wg3_lane u_lane (
      .clk_i    (clk_i),
      .alpha_i  (alpha),
      .beta_i   (wrd_data[k*BETA_W +: BETA_W]),
      .pix_i    (tap_q[k]),
      .centre_i (tap_q[4]),
      .w_o      (lane_w[k]),
      .p_o      (lane_p[k])
    );
  end

  wg3_merge u_merge (
    .clk_i (clk_i),
    .w_i   (lane_w),
    .p_i   (lane_p),
    .den_o (den),
    .num_o (num)
  );

  wg3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .zero_o  (div_zero)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (has_cm1 || has_cc) && (has_rm1 || has_rr)) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = S_FETCH;
      S_FETCH: if (cnt_q == 4'(NTAPS)) state_d = S_CALC;
      S_CALC:  if (cnt_q == 4'd4) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = last_q ? S_IDLE : S_SETUP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rows_q         <= RCFG_W'(1);
      cols_q         <= CCFG_W'(1);
      alpha_edge_q   <= ALPHA_ONE;
      alpha_corner_q <= ALPHA_ONE;
      row_q          <= '0;
      col_q          <= '0;
      ring_q         <= '0;
      cnt_q          <= '0;
      ca_q           <= 1'b0;
      cb_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          REG_ROWS: begin
            if (cfg_data_i[RCFG_W-1:0] == '0) begin
              rows_q <= RCFG_W'(1);
            end else if (cfg_data_i[RCFG_W-1:0] > RCFG_W'(MAX_ROWS)) begin
              rows_q <= RCFG_W'(MAX_ROWS);
            end else begin
              rows_q <= cfg_data_i[RCFG_W-1:0];
            end
            row_q  <= '0;
            col_q  <= '0;
            ring_q <= '0;
          end
          REG_COLS: begin
            if (cfg_data_i[CCFG_W-1:0] == '0) begin
              cols_q <= CCFG_W'(1);
            end else if (cfg_data_i[CCFG_W-1:0] > CCFG_W'(MAX_COLS)) begin
              cols_q <= CCFG_W'(MAX_COLS);
            end else begin
              cols_q <= cfg_data_i[CCFG_W-1:0];
            end
            row_q  <= '0;
            col_q  <= '0;
            ring_q <= '0;
          end
          REG_ALPHA_EDGE: begin
            alpha_edge_q <= (cfg_data_i > CFG_W'(ALPHA_ONE)) ? ALPHA_ONE : cfg_data_i;
          end
          REG_ALPHA_CORNER: begin
            alpha_corner_q <= (cfg_data_i > CFG_W'(ALPHA_ONE)) ? ALPHA_ONE : cfg_data_i;
          end
          default: ;
        endcase
      end
      if (in_xfer) begin
        ca_q <= 1'b0;
        cb_q <= 1'b0;
        // advance to the next pixel position, wrapping row then column
        if ({1'b0, row_q} + RCFG_W'(1) >= rows_q) begin
          row_q <= '0;
          if ({1'b0, col_q} + CCFG_W'(1) >= cols_q) begin
            col_q  <= '0;
            ring_q <= '0;
          end else begin
            col_q  <= col_q + COL_W'(1);
            ring_q <= ring_inc(ring_q);
          end
        end else begin
          row_q <= row_q + ROW_W'(1);
        end
      end
      if (state_q == S_SETUP || state_q == S_DIV) begin
        cnt_q <= '0;
      end else if (state_q == S_FETCH || state_q == S_CALC) begin
        cnt_q <= (state_d != state_q) ? '0 : cnt_q + 4'd1;
      end
      if (state_q == S_DIV && div_done) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_OUT && !out_stall_i) begin
        out_valid_q <= 1'b0;
        if (!last_q) begin
          // advance rows first, then columns
          if (cb_q == (nrows_q == 2'd2)) begin
            cb_q <= 1'b0;
            ca_q <= 1'b1;
          end else begin
            cb_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      job_row_q  <= row_q;
      job_col_q  <= col_q;
      job_ring_q <= ring_q;
      job_cm1_q  <= has_cm1;
      job_rm1_q  <= has_rm1;
      ncols_q    <= 2'(has_cm1) + 2'(has_cc);
      nrows_q    <= 2'(has_rm1) + 2'(has_rr);
    end
    if (state_q == S_SETUP) begin
      ri_q    <= s_i;
      rj_q    <= s_j;
      rowm_q  <= s_rowm;
      rowp_q  <= s_rowp;
      ringm_q <= s_ringm;
      ringc_q <= s_ringc;
      ringp_q <= s_ringp;
      last_q  <= last_res;
    end
    if (state_q == S_FETCH && cnt_q != '0) begin
      tap_q[cnt_q - 4'd1] <= prd_data;
    end
    if (state_q == S_DIV && div_done) begin
      out_q.filtered    <= div_quo;
      out_q.out_row     <= ri_q;
      out_q.out_col     <= rj_q;
      out_q.zero_weight <= div_zero;
      out_q.last_of_run <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_only_in_out_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT))
    else $error("result valid outside output state");

  a_no_input_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !out_valid_o)
    else $error("input transfer while a result is pending");

  a_div_start_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV) && !div_start)
    else $error("divider start not followed by divide state");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule
